@@ design/esct_pkg.sv @@
// Package for the mm:ss countdown timer: beat structs, button phase enum,
// register map and fixed arithmetic constants.
// No dependencies; imported by encoder_set_countdown_timer_top.
package esct_pkg;

    typedef struct packed {
        logic ms_tick;
        logic enc_a;
        logic enc_b;
        logic button_n;
    } esct_in_t;

    typedef struct packed {
        logic [3:0] sec_units;
        logic [2:0] sec_tens;
        logic [3:0] min_units;
        logic [3:0] min_tens;
        logic [1:0] button_phase_out;
    } esct_out_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_STARTED = 2'd1,
        PH_RUNNING = 2'd2,
        PH_CLEAR   = 2'd3
    } phase_t;

    // Register map: the register index is paddr[2].
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic REG_ENCODER_STEP   = 1'b0;
    localparam logic REG_TICK_PERIOD_MS = 1'b1;

    localparam int unsigned STEP_W   = 10;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned SECS_W   = 13;
    localparam int unsigned MINS_W   = 7;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd30;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [SECS_W-1:0]   MAX_SECONDS  = 13'd5999;
    localparam logic [PERIOD_W-1:0] MS_SAT       = 16'hFFFF;

    // Reciprocals: floor(x * 8739 / 2^19) = x / 60 for x <= 5999,
    // floor(x * 205 / 2^11) = x / 10 for x <= 99.
    localparam logic [13:0] DIV60_MULT = 14'd8739;
    localparam logic [7:0]  DIV10_MULT = 8'd205;

endpackage

@@ design/encoder_set_countdown_timer_top.sv @@
// Countdown timer set by a rotary encoder, one beat per millisecond sample.
// Depends on esct_pkg for the beat structs, phase enum and constants.
//
// The block takes one input beat per clock while m_ready does not hold the
// pipeline back, and returns exactly one result beat per input beat. The
// input register feeds the state update (encoder, button phase, millisecond
// counter and remaining seconds), whose registers feed a stage that splits
// seconds into minutes and seconds with one reciprocal multiply, and a last
// stage that splits each into decimal digits. Every stage moves on its own,
// so bubbles are squeezed out, and up to three more inputs are still taken
// while a result waits on m_ready. Registers are written through the APB
// port: encoder_step at 0x0 and tick_period_ms at 0x4; write them only while
// the pipeline is empty.
module encoder_set_countdown_timer_top
    import esct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  esct_in_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output esct_out_t             m_payload,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [STEP_W-1:0]   step_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic                in_valid_reg;
    esct_in_t            in_reg;
    logic                st_valid_reg;
    logic                dv_valid_reg;
    logic                out_valid_reg;
    esct_out_t           out_reg;

    logic [SECS_W-1:0]   rem_reg, rem_next;
    phase_t              phase_reg, phase_next;
    logic                last_a_reg, last_a_next;
    logic [PERIOD_W-1:0] ms_reg, ms_next;

    logic [MINS_W-1:0]   dv_min_reg;
    logic [5:0]          dv_sec_reg;
    phase_t              dv_phase_reg;

    logic adv_out, adv_dv, adv_st, adv_in;

    logic [SECS_W-1:0]   rem_enc, rem_btn;
    logic [SECS_W:0]     enc_sum, btn_sum;
    logic [PERIOD_W-1:0] ms_inc;
    logic                fall_a;

    logic [26:0]         prod60;
    logic [MINS_W-1:0]   min_q;
    logic [SECS_W-1:0]   min_times60;
    logic [SECS_W-1:0]   sec_rem;

    logic [14:0]         prod_min10, prod_sec10;
    logic [3:0]          min_tens_q;
    logic [2:0]          sec_tens_q;
    logic [MINS_W-1:0]   min_units_w;
    logic [5:0]          sec_units_w;

    // Each stage advances when it is empty or the stage after it advances.
    assign adv_out = !out_valid_reg || m_ready;
    assign adv_dv  = !dv_valid_reg || adv_out;
    assign adv_st  = !st_valid_reg || adv_dv;
    assign adv_in  = !in_valid_reg || adv_st;
    assign s_ready = adv_in;
    assign m_valid = out_valid_reg;
    assign m_payload = out_reg;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= STEP_RESET;
            period_reg <= PERIOD_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ENCODER_STEP:   step_reg   <= pwdata[STEP_W-1:0];
                REG_TICK_PERIOD_MS: period_reg <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ENCODER_STEP:   prdata = {{(32-STEP_W){1'b0}}, step_reg};
            REG_TICK_PERIOD_MS: prdata = {{(32-PERIOD_W){1'b0}}, period_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv_in) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in && s_valid) begin
            in_reg <= s_payload;
        end
    end

    // State update for the beat in the input register.
    always_comb begin
        fall_a      = !in_reg.enc_a && last_a_reg;
        last_a_next = in_reg.enc_a;

        // Encoder detent, only while idle.
        enc_sum = {1'b0, rem_reg} + {{(SECS_W+1-STEP_W){1'b0}}, step_reg};
        rem_enc = rem_reg;
        if (fall_a && phase_reg == PH_IDLE) begin
            if (!in_reg.enc_b) begin
                rem_enc = (enc_sum > {1'b0, MAX_SECONDS}) ? MAX_SECONDS
                                                          : enc_sum[SECS_W-1:0];
            end else if ({{(SECS_W-STEP_W){1'b0}}, step_reg} >= rem_reg) begin
                rem_enc = '0;
            end else begin
                rem_enc = rem_reg - {{(SECS_W-STEP_W){1'b0}}, step_reg};
            end
        end

        // Button phases; a start adds one second.
        btn_sum    = {1'b0, rem_enc} + {{SECS_W{1'b0}}, 1'b1};
        rem_btn    = rem_enc;
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (!in_reg.button_n) begin
                    phase_next = PH_STARTED;
                    rem_btn = (btn_sum > {1'b0, MAX_SECONDS}) ? MAX_SECONDS
                                                              : btn_sum[SECS_W-1:0];
                end
            end
            PH_STARTED: begin
                if (in_reg.button_n) begin
                    phase_next = PH_RUNNING;
                end
            end
            PH_RUNNING: begin
                if (!in_reg.button_n) begin
                    phase_next = PH_CLEAR;
                end
            end
            PH_CLEAR: begin
                if (in_reg.button_n) begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        // Countdown.
        ms_inc   = (in_reg.ms_tick && ms_reg != MS_SAT) ? ms_reg + 16'd1 : ms_reg;
        ms_next  = ms_inc;
        rem_next = rem_btn;
        if ((phase_next == PH_STARTED || phase_next == PH_RUNNING) &&
            ms_inc >= period_reg) begin
            ms_next  = '0;
            rem_next = (rem_btn == '0) ? '0 : rem_btn - 13'd1;
        end
        if (phase_next == PH_CLEAR) begin
            rem_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            rem_reg      <= '0;
            phase_reg    <= PH_IDLE;
            last_a_reg   <= 1'b1;
            ms_reg       <= '0;
        end else if (adv_st) begin
            st_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                rem_reg    <= rem_next;
                phase_reg  <= phase_next;
                last_a_reg <= last_a_next;
                ms_reg     <= ms_next;
            end
        end
    end

    // Minutes and seconds.
    assign prod60      = 27'(rem_reg) * 27'(DIV60_MULT);
    assign min_q       = prod60[25:19];
    assign min_times60 = {min_q, 6'b0} - {4'b0, min_q, 2'b0};
    assign sec_rem     = rem_reg - min_times60;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg <= 1'b0;
        end else if (adv_dv) begin
            dv_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_dv && st_valid_reg) begin
            dv_min_reg   <= min_q;
            dv_sec_reg   <= sec_rem[5:0];
            dv_phase_reg <= phase_reg;
        end
    end

    // Decimal digits.
    assign prod_min10  = 15'(dv_min_reg) * 15'(DIV10_MULT);
    assign prod_sec10  = 15'(dv_sec_reg) * 15'(DIV10_MULT);
    assign min_tens_q  = prod_min10[14:11];
    assign sec_tens_q  = prod_sec10[13:11];
    assign min_units_w = dv_min_reg - ({min_tens_q, 3'b0} + {2'b0, min_tens_q, 1'b0});
    assign sec_units_w = dv_sec_reg - ({sec_tens_q, 3'b0} + {2'b0, sec_tens_q, 1'b0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv_out) begin
            out_valid_reg <= dv_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && dv_valid_reg) begin
            out_reg.min_tens         <= min_tens_q;
            out_reg.min_units        <= min_units_w[3:0];
            out_reg.sec_tens         <= sec_tens_q;
            out_reg.sec_units        <= sec_units_w[3:0];
            out_reg.button_phase_out <= dv_phase_reg;
        end
    end

    // The count never leaves the displayable range.
    a_rem_max: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= MAX_SECONDS)
        else $error("remaining seconds above 99:59");

    // The reset phase always shows zero.
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CLEAR |-> rem_reg == '0)
        else $error("count not zero in reset phase");

    // A result beat always carries valid decimal digits.
    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.sec_units <= 4'd9 && out_reg.sec_tens <= 3'd5 &&
                           out_reg.min_units <= 4'd9 && out_reg.min_tens <= 4'd9))
        else $error("digit out of range");

    // The state only moves when a beat leaves the input register.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_valid_reg && adv_st) |=> $stable(rem_reg) && $stable(phase_reg))
        else $error("state changed without a beat");

endmodule

@@ bench/encoder_set_countdown_timer_top_tb.sv @@
// Self-checking bench for encoder_set_countdown_timer_top: a behavioral
// countdown predictor, valid/ready drivers with random idling and APB writes.
// Depends on esct_pkg and the encoder_set_countdown_timer_top RTL.
`timescale 1ns / 1ps

module encoder_set_countdown_timer_top_tb;
    import esct_pkg::*;

    localparam int unsigned TOP_SECONDS   = 5999;
    localparam int unsigned MS_CEILING    = 65535;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned STALL_LIMIT   = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    esct_in_t              s_payload;
    logic                  m_valid;
    logic                  m_ready;
    esct_out_t             m_payload;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Predicted timer state and register copies.
    logic [9:0]  cfg_step;
    logic [15:0] cfg_period;
    logic [12:0] remaining;
    phase_t      btn_phase;
    logic        last_a;
    logic [15:0] ms_elapsed;

    esct_out_t   expected_display[$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned stall_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    encoder_set_countdown_timer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Applies one millisecond sample to the predicted state and returns the display.
    function automatic esct_out_t advance_timer(esct_in_t smp);
        int unsigned secs;
        esct_out_t   shown;
        secs = remaining;
        if (!smp.enc_a && last_a) begin
            last_a = 1'b0;
            if (btn_phase == PH_IDLE) begin
                if (!smp.enc_b)
                    secs = (secs + cfg_step > TOP_SECONDS) ? TOP_SECONDS : secs + cfg_step;
                else
                    secs = (cfg_step >= secs) ? 0 : secs - cfg_step;
            end
        end
        if (smp.enc_a) begin
            last_a = 1'b1;
        end
        case (btn_phase)
            PH_IDLE: if (!smp.button_n) begin
                btn_phase = PH_STARTED;
                secs = (secs + 1 > TOP_SECONDS) ? TOP_SECONDS : secs + 1;
            end
            PH_STARTED: if (smp.button_n) btn_phase = PH_RUNNING;
            PH_RUNNING: if (!smp.button_n) btn_phase = PH_CLEAR;
            default: if (smp.button_n) btn_phase = PH_IDLE;
        endcase
        if (smp.ms_tick && ms_elapsed != MS_CEILING) begin
            ms_elapsed = ms_elapsed + 1'b1;
        end
        if ((btn_phase == PH_STARTED || btn_phase == PH_RUNNING) && ms_elapsed >= cfg_period) begin
            if (secs > 0) secs = secs - 1;
            ms_elapsed = '0;
        end
        if (btn_phase == PH_CLEAR) begin
            secs = 0;
        end
        remaining = secs[12:0];
        shown.min_tens = 4'(secs / 600);
        shown.min_units = 4'((secs % 600) / 60);
        shown.sec_tens = 3'((secs % 60) / 10);
        shown.sec_units = 4'(secs % 10);
        shown.button_phase_out = btn_phase;
        return shown;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Scoreboard and watchdog, both sampled at the rising edge.
    always @(posedge aclk) begin
        esct_out_t want;
        bit        moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_display.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_payload);
                    mismatch_count++;
                end else begin
                    want = expected_display.pop_front();
                    check_field("sec_units", want.sec_units, m_payload.sec_units);
                    check_field("sec_tens", want.sec_tens, m_payload.sec_tens);
                    check_field("min_units", want.min_units, m_payload.min_units);
                    check_field("min_tens", want.min_tens, m_payload.min_tens);
                    check_field("button_phase_out", want.button_phase_out,
                                m_payload.button_phase_out);
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                expected_display.push_back(advance_timer(s_payload));
            end
            if (psel && penable) begin
                moved = 1'b1;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, stall_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic esct_in_t pack_sample(logic tick, logic a, logic b, logic btn_n);
        esct_in_t smp;
        smp.ms_tick = tick;
        smp.enc_a = a;
        smp.enc_b = b;
        smp.button_n = btn_n;
        return smp;
    endfunction

    // Valid stays high on return; the next caller either replaces the beat or drops valid.
    task automatic send_sample(esct_in_t smp);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= smp;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic detent(logic b);
        send_sample(pack_sample(1'($urandom_range(0, 1)), 1'b1,
                                1'($urandom_range(0, 1)), 1'b1));
        send_sample(pack_sample(1'($urandom_range(0, 1)), 1'b0, b, 1'b1));
    endtask

    // Holds the input back until every predicted display has come out.
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_display.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(logic regsel, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (regsel == REG_ENCODER_STEP)
            cfg_step = value[9:0];
        else
            cfg_period = value[15:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle_and_configure(logic [31:0] step_val, logic [31:0] period_val);
        quiesce();
        apb_write(REG_ENCODER_STEP, step_val);
        apb_write(REG_TICK_PERIOD_MS, period_val);
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd600;
            3: return 32'd1023;
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd1000;
            default: return $urandom_range(2, 20);
        endcase
    endfunction

    // Detents at the reset step, including a subtraction below zero.
    task automatic test_encoder_edges();
        send_sample(pack_sample(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b1));
        send_sample(pack_sample(1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(pack_sample(1'b0, 1'b1, 1'b1, 1'b1));
        send_sample(pack_sample(1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(pack_sample(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(pack_sample(1'b1, 1'b1, 1'b0, 1'b1));
    endtask

    // Largest step saturates at 99:59; a zero step leaves the count alone.
    task automatic test_step_extremes();
        quiesce();
        apb_write(REG_ENCODER_STEP, 32'd1023);
        repeat (6) detent(1'b0);
        quiesce();
        apb_write(REG_ENCODER_STEP, 32'd0);
        detent(1'b1);
    endtask

    // Walks all four button phases with a zero period, so every beat in the started and running phases decrements.
    task automatic test_button_phases();
        quiesce();
        apb_write(REG_TICK_PERIOD_MS, 32'd0);
        send_sample(pack_sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b1));
        send_sample(pack_sample(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(pack_sample(1'b1, 1'b1, 1'b1, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b1, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b1, 1'b1));
        // Start from zero: the added second is taken back at once and the count stays at zero.
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b1));
        send_sample(pack_sample(1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b1));
    endtask

    // Mostly well-formed detents, clicks and tick bursts, with some raw noise.
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned target;
        bit          reconfigured;
        target = items_sent + n_items;
        reconfigured = 1'b0;
        settle_and_configure(pick_step(), pick_period());
        while (items_sent < target) begin
            if (!reconfigured && items_sent + n_items / 2 >= target) begin
                settle_and_configure(pick_step(), pick_period());
                reconfigured = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: detent(1'($urandom_range(0, 1)));
                4, 5: begin
                    repeat ($urandom_range(1, 3))
                        send_sample(pack_sample(1'($urandom_range(0, 1)), 1'b1,
                                                1'($urandom_range(0, 1)), 1'b0));
                    send_sample(pack_sample(1'($urandom_range(0, 1)), 1'b1,
                                            1'($urandom_range(0, 1)), 1'b1));
                end
                6, 7: repeat ($urandom_range(1, 12))
                    send_sample(pack_sample($urandom_range(0, 7) != 0, 1'b1,
                                            1'($urandom_range(0, 1)), 1'b1));
                default: send_sample(esct_in_t'(4'($urandom_range(0, 15))));
            endcase
        end
    endtask

    // Longest period: a run of ticks well short of it must not decrement the count.
    task automatic test_long_period();
        settle_and_configure(32'd30, 32'd65535);
        detent(1'b0);
        repeat (40) send_sample(pack_sample(1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(pack_sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b1));
        repeat (5) send_sample(pack_sample(1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(pack_sample(1'b0, 1'b1, 1'b0, 1'b1));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_step = 10'd30;
        cfg_period = 16'd1000;
        remaining = '0;
        btn_phase = PH_IDLE;
        last_a = 1'b1;
        ms_elapsed = '0;
        mismatch_count = 0;
        items_sent = 0;
        stall_cycles = 0;
        send_idle_pct = 20;
        recv_idle_pct = 54;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_encoder_edges();
        test_step_extremes();
        test_button_phases();
        test_random_traffic(110);
        send_idle_pct = 54;
        recv_idle_pct = 20;
        test_random_traffic(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);
        test_long_period();

        quiesce();
        repeat (10) @(posedge aclk);
        if (expected_display.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_display.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
